[sv/pcm_pkg.sv]
// shared types and constants of the priority command multiplexer
// no dependencies
package pcm_pkg;

  localparam int NumSources   = 5;
  localparam int VelWidth     = 32;
  localparam int AgeWidth     = 16;
  localparam int NumComp      = 6;
  localparam int SrcWidth     = 3;
  localparam int CntWidth     = 32;
  localparam int CfgIdxWidth  = 3;
  localparam int CfgDataWidth = 16;
  localparam int QueueDepth   = 2;
  localparam int QPtrWidth    = 1;
  localparam int QCntWidth    = 2;

  localparam logic [SrcWidth-1:0] SrcEmergency = SrcWidth'(0);
  localparam logic [SrcWidth-1:0] SrcManual    = SrcWidth'(1);
  localparam logic [SrcWidth-1:0] SrcAuto      = SrcWidth'(3);
  localparam logic [SrcWidth-1:0] SelNone      = SrcWidth'(NumSources);

  localparam logic [AgeWidth-1:0]     AgeMax   = '1;
  localparam logic [CfgDataWidth-1:0] DefTo    = CfgDataWidth'(500);
  localparam logic [CfgDataWidth-1:0] EmergTo  = CfgDataWidth'(1000);
  localparam logic [CfgDataWidth-1:0] AutoTo   = CfgDataWidth'(2000);
  localparam logic [QCntWidth-1:0]    QFull    = QCntWidth'(QueueDepth);

  typedef enum logic [1:0] {
    OpCommand,
    OpDeadman,
    OpTick,
    OpArbitrate
  } op_e;

  typedef enum logic [CfgIdxWidth-1:0] {
    CfgEnabled,
    CfgDeadmanReq,
    CfgDefaultTo,
    CfgEmergencyTo,
    CfgAutoTo
  } cfg_idx_e;

  typedef logic [NumComp-1:0][VelWidth-1:0] vel_vec_t;

  typedef struct packed {
    op_e                 op;
    logic [SrcWidth-1:0] source;
    logic                src_ok;
    logic                deadman_level;
    vel_vec_t            vel;
  } cmd_t;

  typedef struct packed {
    logic [SrcWidth-1:0] selected;
    vel_vec_t            vel;
    logic                changed;
    logic [CntWidth-1:0] switch_total;
    logic [CntWidth-1:0] blocked_total;
    logic                deadman_now;
  } res_t;

endpackage

[sv/pcm_front.sv]
// front end: takes input items, classifies them and queues them for the back end
// depends on pcm_pkg
module pcm_front (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              push_i,
  output logic                              full_o,
  input  logic [1:0]                        kind_i,
  input  logic [pcm_pkg::SrcWidth-1:0]      source_i,
  input  logic signed [pcm_pkg::VelWidth-1:0] lin_x_i,
  input  logic signed [pcm_pkg::VelWidth-1:0] lin_y_i,
  input  logic signed [pcm_pkg::VelWidth-1:0] lin_z_i,
  input  logic signed [pcm_pkg::VelWidth-1:0] ang_x_i,
  input  logic signed [pcm_pkg::VelWidth-1:0] ang_y_i,
  input  logic signed [pcm_pkg::VelWidth-1:0] ang_z_i,
  input  logic                              deadman_level_i,
  output logic                              cmd_valid_o,
  output pcm_pkg::cmd_t                     cmd_o,
  input  logic                              cmd_pop_i
);
  import pcm_pkg::*;

  cmd_t                 mem_q [QueueDepth];
  logic [QPtrWidth-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [QCntWidth-1:0] cnt_q, cnt_d;
  cmd_t                 item;
  logic                 do_push, do_pop;

  always_comb begin
    item.op            = op_e'(kind_i);
    item.source        = source_i;
    item.src_ok        = (source_i < SelNone);
    item.deadman_level = deadman_level_i;
    item.vel           = {ang_z_i, ang_y_i, ang_x_i, lin_z_i, lin_y_i, lin_x_i};
  end

  assign full_o      = (cnt_q == QFull);
  assign cmd_valid_o = (cnt_q != '0);
  assign cmd_o       = mem_q[rd_ptr_q];
  assign do_push     = push_i && !full_o;
  assign do_pop      = cmd_pop_i && cmd_valid_o;

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q + QCntWidth'(do_push) - QCntWidth'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= item;
    end
  end

endmodule

[sv/pcm_back.sv]
// back end: source state, timeouts, priority selection and counters
// depends on pcm_pkg
module pcm_back (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [pcm_pkg::CfgIdxWidth-1:0]     cfg_idx_i,
  input  logic [pcm_pkg::CfgDataWidth-1:0]    cfg_wdata_i,
  input  logic                                cmd_valid_i,
  input  pcm_pkg::cmd_t                       cmd_i,
  output logic                                cmd_pop_o,
  input  logic                                res_full_i,
  output logic                                res_push_o,
  output pcm_pkg::res_t                       res_o
);
  import pcm_pkg::*;

  logic                    en_q, dm_req_q, dm_q;
  logic [CfgDataWidth-1:0] def_to_q, emerg_to_q, auto_to_q;
  logic [NumSources-1:0]   valid_q;
  logic [AgeWidth-1:0]     age_q [NumSources];
  vel_vec_t                vel_q [NumSources];
  logic [SrcWidth-1:0]     choice_q;
  logic [CntWidth-1:0]     switch_q, blocked_q;

  logic [CfgDataWidth-1:0] to_s [NumSources];
  logic [NumSources-1:0]   valid_live;
  logic                    gated, is_arb, is_cmd, cmd_block, cmd_store, do_op, sel_diff;
  logic [SrcWidth-1:0]     sel;
  logic [CntWidth-1:0]     switch_nx;

  assign gated  = dm_req_q && !dm_q;
  assign is_arb = (cmd_i.op == OpArbitrate);
  assign is_cmd = (cmd_i.op == OpCommand);

  always_comb begin
    for (int s = 0; s < NumSources; s++) begin
      if (SrcWidth'(s) == SrcEmergency) begin
        to_s[s] = emerg_to_q;
      end else if (SrcWidth'(s) == SrcAuto) begin
        to_s[s] = auto_to_q;
      end else begin
        to_s[s] = def_to_q;
      end
      valid_live[s] = valid_q[s] && !(AgeWidth'(to_s[s]) < age_q[s]);
    end
  end

  always_comb begin
    sel = SelNone;
    for (int s = NumSources - 1; s >= 0; s--) begin
      if (valid_live[s] && !((SrcWidth'(s) == SrcManual) && gated)) begin
        sel = SrcWidth'(s);
      end
    end
  end

  assign sel_diff   = (sel != choice_q);
  assign switch_nx  = sel_diff ? switch_q + CntWidth'(1) : switch_q;
  assign cmd_block  = !en_q || !cmd_i.src_ok || ((cmd_i.source == SrcManual) && gated);
  assign cmd_store  = is_cmd && !cmd_block;

  assign res_push_o = cmd_valid_i && is_arb && en_q && !res_full_i;
  assign do_op      = cmd_valid_i && (!(is_arb && en_q) || !res_full_i);
  assign cmd_pop_o  = do_op;

  always_comb begin
    res_o.selected      = sel;
    res_o.vel           = (sel == SelNone) ? '0 : vel_q[sel];
    res_o.changed       = sel_diff;
    res_o.switch_total  = switch_nx;
    res_o.blocked_total = blocked_q;
    res_o.deadman_now   = dm_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q       <= 1'b0;
      dm_req_q   <= 1'b1;
      def_to_q   <= DefTo;
      emerg_to_q <= EmergTo;
      auto_to_q  <= AutoTo;
      valid_q    <= '0;
      dm_q       <= 1'b0;
      choice_q   <= SelNone;
      switch_q   <= '0;
      blocked_q  <= '0;
      for (int s = 0; s < NumSources; s++) begin
        age_q[s] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_e'(cfg_idx_i))
          CfgEnabled:     en_q       <= cfg_wdata_i[0];
          CfgDeadmanReq:  dm_req_q   <= cfg_wdata_i[0];
          CfgDefaultTo:   def_to_q   <= cfg_wdata_i;
          CfgEmergencyTo: emerg_to_q <= cfg_wdata_i;
          CfgAutoTo:      auto_to_q  <= cfg_wdata_i;
          default: ;
        endcase
      end
      if (do_op) begin
        unique case (cmd_i.op)
          OpCommand: begin
            if (cmd_block) begin
              blocked_q <= blocked_q + CntWidth'(1);
              if (en_q && cmd_i.src_ok) begin
                valid_q[SrcManual] <= 1'b0;
              end
            end else begin
              valid_q[cmd_i.source] <= 1'b1;
              age_q[cmd_i.source]   <= '0;
            end
          end
          OpDeadman: dm_q <= cmd_i.deadman_level;
          OpTick: begin
            for (int s = 0; s < NumSources; s++) begin
              if (age_q[s] != AgeMax) begin
                age_q[s] <= age_q[s] + AgeWidth'(1);
              end
            end
          end
          OpArbitrate: begin
            if (en_q) begin
              valid_q  <= valid_live;
              choice_q <= sel;
              switch_q <= switch_nx;
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_op && cmd_store) begin
      vel_q[cmd_i.source] <= cmd_i.vel;
    end
  end

endmodule

[sv/pcm_out_q.sv]
// result queue between the back end and the result ports
// depends on pcm_pkg
module pcm_out_q (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  pcm_pkg::res_t res_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          empty_o,
  output pcm_pkg::res_t res_o
);
  import pcm_pkg::*;

  res_t                 mem_q [QueueDepth];
  logic [QPtrWidth-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCntWidth-1:0] cnt_q;
  logic                 do_push, do_pop;

  assign full_o  = (cnt_q == QFull);
  assign empty_o = (cnt_q == '0);
  assign res_o   = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      cnt_q <= cnt_q + QCntWidth'(do_push) - QCntWidth'(do_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= res_i;
    end
  end

endmodule

[sv/priority_command_mux_with_timeouts.sv]
// Priority velocity command multiplexer with per-source timeouts. Items go in through a
// push/full queue port and results come out through an empty/pop queue port; only an
// arbitrate item while enabled gives a result. One item is taken every clock cycle unless the
// input queue is full or an arbitrate item at its head waits for room in the result queue.
// The back end's execute stage handles any item kind; results are registered in a queue.
// Short queues on both sides let the input side keep accepting while results wait to be popped.
// depends on pcm_pkg, pcm_front, pcm_back, pcm_out_q
module priority_command_mux_with_timeouts (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [pcm_pkg::CfgIdxWidth-1:0]       cfg_idx_i,
  input  logic [pcm_pkg::CfgDataWidth-1:0]      cfg_wdata_i,
  input  logic                                  push,
  output logic                                  full,
  input  logic [1:0]                            kind_i,
  input  logic [pcm_pkg::SrcWidth-1:0]          source_i,
  input  logic signed [pcm_pkg::VelWidth-1:0]   lin_x_i,
  input  logic signed [pcm_pkg::VelWidth-1:0]   lin_y_i,
  input  logic signed [pcm_pkg::VelWidth-1:0]   lin_z_i,
  input  logic signed [pcm_pkg::VelWidth-1:0]   ang_x_i,
  input  logic signed [pcm_pkg::VelWidth-1:0]   ang_y_i,
  input  logic signed [pcm_pkg::VelWidth-1:0]   ang_z_i,
  input  logic                                  deadman_level_i,
  output logic                                  empty,
  input  logic                                  pop,
  output logic [pcm_pkg::SrcWidth-1:0]          selected_o,
  output logic signed [pcm_pkg::VelWidth-1:0]   out_lin_x_o,
  output logic signed [pcm_pkg::VelWidth-1:0]   out_lin_y_o,
  output logic signed [pcm_pkg::VelWidth-1:0]   out_lin_z_o,
  output logic signed [pcm_pkg::VelWidth-1:0]   out_ang_x_o,
  output logic signed [pcm_pkg::VelWidth-1:0]   out_ang_y_o,
  output logic signed [pcm_pkg::VelWidth-1:0]   out_ang_z_o,
  output logic                                  changed_o,
  output logic [pcm_pkg::CntWidth-1:0]          switch_total_o,
  output logic [pcm_pkg::CntWidth-1:0]          blocked_total_o,
  output logic                                  deadman_now_o
);
  import pcm_pkg::*;

  cmd_t cmd;
  logic cmd_valid, cmd_pop;
  res_t res_in, res_out;
  logic res_push, res_full;

  pcm_front u_front (
    .clk_i,
    .rst_ni,
    .push_i      (push),
    .full_o      (full),
    .kind_i,
    .source_i,
    .lin_x_i,
    .lin_y_i,
    .lin_z_i,
    .ang_x_i,
    .ang_y_i,
    .ang_z_i,
    .deadman_level_i,
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  pcm_back u_back (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_wdata_i,
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_o       (res_in)
  );

  pcm_out_q u_out_q (
    .clk_i,
    .rst_ni,
    .push_i  (res_push),
    .res_i   (res_in),
    .full_o  (res_full),
    .pop_i   (pop),
    .empty_o (empty),
    .res_o   (res_out)
  );

  assign selected_o      = res_out.selected;
  assign out_lin_x_o     = res_out.vel[0];
  assign out_lin_y_o     = res_out.vel[1];
  assign out_lin_z_o     = res_out.vel[2];
  assign out_ang_x_o     = res_out.vel[3];
  assign out_ang_y_o     = res_out.vel[4];
  assign out_ang_z_o     = res_out.vel[5];
  assign changed_o       = res_out.changed;
  assign switch_total_o  = res_out.switch_total;
  assign blocked_total_o = res_out.blocked_total;
  assign deadman_now_o   = res_out.deadman_now;

endmodule
